// ===== src/vertex_transform_bounds_macros.svh =====
// Assertion macros used by the checker file of the vertex bounds block.
`ifndef VERTEX_TRANSFORM_BOUNDS_MACROS_SVH
`define VERTEX_TRANSFORM_BOUNDS_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define VTB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define VTB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/vtb_pkg.sv =====
// Types, constants and helper functions for the vertex transform bounds block.
`default_nettype none

package vtb_pkg;

  localparam int CoordW     = 24;
  localparam int CoeffW     = 16;
  localparam int ProdW      = CoordW + CoeffW;
  localparam int SumW       = ProdW + 2;
  localparam int RoundShift = 14;
  localparam int RndW       = SumW - RoundShift;
  localparam int OffSumW    = RndW + 1;
  localparam int CfgDataW   = 3 * CoeffW;
  localparam int CfgIdxW    = 3;

  // A vertex holds its credit until the accumulator takes it, so five credits keep
  // a steady, unstalled stream of one vertex per cycle from ever seeing full.
  localparam int DefaultQueueDepth = 5;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [CoeffW-1:0] coeff_t;

  localparam coord_t CoordMax = 24'sh7FFFFF;
  localparam coord_t CoordMin = 24'sh800000;

  localparam logic [CfgDataW-1:0] RowXReset = 48'h0000_0000_4000;
  localparam logic [CfgDataW-1:0] RowYReset = 48'h0000_4000_0000;
  localparam logic [CfgDataW-1:0] RowZReset = 48'h4000_0000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowX = 3'd0,
    CfgRowY = 3'd1,
    CfgRowZ = 3'd2,
    CfgOffX = 3'd3,
    CfgOffY = 3'd4,
    CfgOffZ = 3'd5
  } cfg_idx_e;

  // One transformed vertex as it travels from the front end to the accumulators.
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   last;
  } vtx_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } bounds_t;

  localparam bounds_t BoundsInit = '{
    min_x: CoordMax, min_y: CoordMax, min_z: CoordMax,
    max_x: CoordMin, max_y: CoordMin, max_z: CoordMin
  };

  // Clamp a widened coordinate into the 24-bit range.
  function automatic coord_t sat_coord(input logic signed [OffSumW-1:0] v);
    logic [OffSumW-CoordW:0] upper;
    upper = v[OffSumW-1:CoordW-1];
    if ((&upper) || (~|upper)) begin
      return v[CoordW-1:0];
    end else if (v[OffSumW-1]) begin
      return CoordMin;
    end else begin
      return CoordMax;
    end
  endfunction

  function automatic coord_t coord_min(input coord_t a, input coord_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic coord_t coord_max(input coord_t a, input coord_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

`default_nettype wire

// ===== src/vtb_front.sv =====
// Front end: configuration registers, two-stage affine transform and credit count.
`default_nettype none

module vtb_front #(
  parameter int QueueDepth = vtb_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vtb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          accept_i,
  input  vtb_pkg::coord_t               vertex_x_i,
  input  vtb_pkg::coord_t               vertex_y_i,
  input  vtb_pkg::coord_t               vertex_z_i,
  input  logic                          last_vertex_i,
  input  logic                          release_i,
  output logic                          full_o,
  output logic                          item_valid_o,
  output vtb_pkg::vtx_t                 item_o
);
  import vtb_pkg::*;

  localparam int CntW = $clog2(QueueDepth + 1);
  localparam logic signed [SumW-1:0] RoundBias = SumW'(1) <<< (RoundShift - 1);

  logic [CfgDataW-1:0]       row_q [3];
  coord_t                    off_q [3];
  coord_t                    vin [3];
  logic signed [ProdW-1:0]   prod_d [3][3];
  logic signed [ProdW-1:0]   prod_q [3][3];
  logic signed [SumW-1:0]    sum_d [3];
  logic signed [RndW-1:0]    rnd_q [3];
  logic signed [OffSumW-1:0] off_sum [3];
  coord_t                    coord_d [3];
  logic                      s1_valid_q, s2_valid_q;
  logic                      s1_last_q, s2_last_q;
  logic [CntW-1:0]           credit_q, credit_d;

  // Configuration writes; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= RowXReset;
      row_q[1] <= RowYReset;
      row_q[2] <= RowZReset;
      off_q[0] <= '0;
      off_q[1] <= '0;
      off_q[2] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgRowX: row_q[0] <= cfg_data_i;
        CfgRowY: row_q[1] <= cfg_data_i;
        CfgRowZ: row_q[2] <= cfg_data_i;
        CfgOffX: off_q[0] <= cfg_data_i[CoordW-1:0];
        CfgOffY: off_q[1] <= cfg_data_i[CoordW-1:0];
        CfgOffZ: off_q[2] <= cfg_data_i[CoordW-1:0];
        default: ;
      endcase
    end
  end

  assign vin[0] = vertex_x_i;
  assign vin[1] = vertex_y_i;
  assign vin[2] = vertex_z_i;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar j = 0; j < 3; j++) begin : g_term
      coeff_t coeff;
      assign coeff       = row_q[a][CoeffW*j +: CoeffW];
      assign prod_d[a][j] = ProdW'(coeff) * ProdW'(vin[j]);
    end

    // Exact sum of three Q.22 products, rounded half up to Q.8.
    assign sum_d[a] = SumW'(prod_q[a][0]) + SumW'(prod_q[a][1]) + SumW'(prod_q[a][2])
                      + RoundBias;
    assign off_sum[a] = OffSumW'(rnd_q[a]) + OffSumW'(off_q[a]);
    assign coord_d[a] = sat_coord(off_sum[a]);
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int j = 0; j < 3; j++) begin
        prod_q[a][j] <= prod_d[a][j];
      end
      rnd_q[a] <= RndW'(sum_d[a] >>> RoundShift);
    end
    s1_last_q <= last_vertex_i;
    s2_last_q <= s1_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      credit_q   <= '0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      credit_q   <= credit_d;
    end
  end

  // A credit is held from acceptance until the accumulator takes the vertex.
  always_comb begin
    credit_d = credit_q;
    if (accept_i && !release_i) begin
      credit_d = credit_q + CntW'(1);
    end else if (!accept_i && release_i) begin
      credit_d = credit_q - CntW'(1);
    end
  end

  assign full_o       = (credit_q == CntW'(QueueDepth));
  assign item_valid_o = s2_valid_q;
  assign item_o       = '{x: coord_d[0], y: coord_d[1], z: coord_d[2], last: s2_last_q};

endmodule

`default_nettype wire

// ===== src/vtb_queue.sv =====
// Small first-in first-out queue between the front end and the accumulators.
`default_nettype none

module vtb_queue #(
  parameter int Width = 1,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assign rdata_o = mem_q[rd_ptr_q];
  assign empty_o = (count_q == '0);

endmodule

`default_nettype wire

// ===== src/vtb_back.sv =====
// Back end: per-axis running bounds and the registered result.
`default_nettype none

module vtb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             item_valid_i,
  input  vtb_pkg::vtx_t    item_i,
  output logic             item_pop_o,
  output logic             res_valid_o,
  input  logic             res_pop_i,
  output vtb_pkg::bounds_t res_o
);
  import vtb_pkg::*;

  bounds_t run_q, run_d;
  bounds_t fold;
  bounds_t res_q;
  logic    res_valid_q, res_valid_d;
  logic    res_free;

  // Running bounds with the incoming vertex folded in.
  always_comb begin
    fold.min_x = coord_min(run_q.min_x, item_i.x);
    fold.min_y = coord_min(run_q.min_y, item_i.y);
    fold.min_z = coord_min(run_q.min_z, item_i.z);
    fold.max_x = coord_max(run_q.max_x, item_i.x);
    fold.max_y = coord_max(run_q.max_y, item_i.y);
    fold.max_z = coord_max(run_q.max_z, item_i.z);
  end

  // A closing vertex waits only while an earlier result is still unread.
  assign res_free   = !res_valid_q || res_pop_i;
  assign item_pop_o = item_valid_i && (!item_i.last || res_free);

  always_comb begin
    run_d       = run_q;
    res_valid_d = res_valid_q && !res_pop_i;
    if (item_pop_o) begin
      run_d = item_i.last ? BoundsInit : fold;
      if (item_i.last) begin
        res_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= BoundsInit;
      res_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_pop_o && item_i.last) begin
      res_q <= fold;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== src/vertex_transform_bounds.sv =====
// Top level of the transformed vertex bounding box block.
`default_nettype none

// Computes the axis-aligned bounds of a primitive's vertices after an affine
// transform. Each vertex (signed Q16.8) is multiplied by a 3x3 matrix of signed
// Q2.14 coefficients, rounded half up to Q16.8, offset by a Q16.8 translation and
// clamped to 24 bits; per-axis minima and maxima are kept, and the vertex marked
// last closes the primitive, makes one result of six bounds and re-arms the
// accumulators. The block takes one vertex per cycle while full is low. A vertex
// passes the transform pipeline (products, then sum and rounding), the
// translation and clamp happen as it is written into a short queue, and the
// accumulator takes it from the head of the queue, writing the bounds of a
// closing vertex into the result register that drives the output. The input
// reports full once QueueDepth vertices have been transferred in but not yet
// taken by the accumulator; at the default depth of five this never throttles a
// steady stream. The accumulator holds back a closing vertex only while the
// previous result is still waiting to be popped, and that back-pressure then
// reaches the input through the queue. Configuration writes take effect at once
// and are to be made only while no vertex is in flight.
module vertex_transform_bounds #(
  parameter int QueueDepth = vtb_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vtb_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [vtb_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  vtb_pkg::coord_t               vertex_x_i,
  input  vtb_pkg::coord_t               vertex_y_i,
  input  vtb_pkg::coord_t               vertex_z_i,
  input  logic                          last_vertex_i,
  output logic                          empty,
  input  logic                          pop,
  output vtb_pkg::coord_t               min_x_o,
  output vtb_pkg::coord_t               min_y_o,
  output vtb_pkg::coord_t               min_z_o,
  output vtb_pkg::coord_t               max_x_o,
  output vtb_pkg::coord_t               max_y_o,
  output vtb_pkg::coord_t               max_z_o
);
  import vtb_pkg::*;

  logic    accept;
  logic    front_valid;
  vtx_t    front_item;
  logic    queue_empty;
  vtx_t    queue_item;
  logic    back_pop;
  logic    res_valid;
  bounds_t res;

  // A vertex transfer needs a free credit, which guarantees a queue slot.
  assign accept = push && !full;

  vtb_front #(
    .QueueDepth (QueueDepth)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .vertex_x_i    (vertex_x_i),
    .vertex_y_i    (vertex_y_i),
    .vertex_z_i    (vertex_z_i),
    .last_vertex_i (last_vertex_i),
    .release_i     (back_pop),
    .full_o        (full),
    .item_valid_o  (front_valid),
    .item_o        (front_item)
  );

  vtb_queue #(
    .Width ($bits(vtx_t)),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .wdata_i (front_item),
    .pop_i   (back_pop),
    .rdata_o (queue_item),
    .empty_o (queue_empty)
  );

  vtb_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (!queue_empty),
    .item_i       (queue_item),
    .item_pop_o   (back_pop),
    .res_valid_o  (res_valid),
    .res_pop_i    (pop),
    .res_o        (res)
  );

  // The result register is the output side of the block.
  assign empty   = !res_valid;
  assign min_x_o = res.min_x;
  assign min_y_o = res.min_y;
  assign min_z_o = res.min_z;
  assign max_x_o = res.max_x;
  assign max_y_o = res.max_y;
  assign max_z_o = res.max_z;

endmodule

`default_nettype wire

// ===== src/vtb_checker.sv =====
// Port-level checker for the vertex bounds block and its bind statement.
`default_nettype none
`include "vertex_transform_bounds_macros.svh"

module vtb_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          push,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input vtb_pkg::coord_t               min_x_o,
  input vtb_pkg::coord_t               min_y_o,
  input vtb_pkg::coord_t               min_z_o,
  input vtb_pkg::coord_t               max_x_o,
  input vtb_pkg::coord_t               max_y_o,
  input vtb_pkg::coord_t               max_z_o
);
  import vtb_pkg::*;

  logic bounds_ok;

  assign bounds_ok = (min_x_o <= max_x_o) && (min_y_o <= max_y_o) && (min_z_o <= max_z_o);

  // Every result covers at least one vertex, so its bounds are never inverted.
  `VTB_ASSERT_IMP(a_bounds_ordered, !empty, bounds_ok, "result bounds inverted")

  // The credit count only grows through an input transfer.
  `VTB_ASSERT_IMP(a_full_after_push, $rose(full), $past(push) && !$past(full), "full rose without a transfer")

  // A waiting result stays put until it is popped.
  `VTB_ASSERT_NXT(a_result_held, !empty && !pop, !empty && $stable(min_x_o) && $stable(max_z_o), "unpopped result changed")

endmodule

bind vertex_transform_bounds vtb_checker u_vtb_checker (.*);

`default_nettype wire
